@@ design/acr_pkg.sv @@
package acr_pkg;

  localparam int CoordWidth = 32;
  // guard bits keep ln and hn wide enough that rounding stays exact
  localparam int GuardBits  = 62 - CoordWidth;
  localparam int MagWidth   = CoordWidth + 1;
  localparam int SqWidth    = 2 * MagWidth;
  localparam int RootWidth  = (SqWidth + 2 * GuardBits) / 2;
  localparam int SplitLo    = (RootWidth + 1) / 2;
  localparam int SplitHi    = RootWidth - SplitLo;
  localparam int ProdWidth  = MagWidth + RootWidth;
  localparam int NumWidth   = ProdWidth + 1;
  localparam int SumWidth   = NumWidth + 1;
  localparam int DenWidth   = RootWidth + 1;
  localparam int QuotWidth  = CoordWidth - 1;

  typedef enum logic [1:0] {
    StOk    = 2'd0,
    StShort = 2'd1,
    StZero  = 2'd2
  } status_e;

  typedef struct packed {
    logic signed [CoordWidth-1:0] start_x;
    logic signed [CoordWidth-1:0] start_y;
    logic signed [CoordWidth-1:0] end_x;
    logic signed [CoordWidth-1:0] end_y;
    logic [CoordWidth-2:0]        arc_radius;
    logic                         concave;
  } arc_in_t;

  typedef struct packed {
    logic signed [CoordWidth-1:0] centre_x;
    logic signed [CoordWidth-1:0] centre_y;
    status_e                      status;
  } arc_out_t;

  // sign/magnitude of the coordinate sums and the chord
  typedef struct packed {
    logic [MagWidth-1:0] sx_mag;
    logic [MagWidth-1:0] sy_mag;
    logic [MagWidth-1:0] vx_mag;
    logic [MagWidth-1:0] vy_mag;
    logic                sx_neg;
    logic                sy_neg;
    logic                vx_neg;
    logic                vy_neg;
    logic                concave;
    status_e             status;
  } side_t;

  typedef struct packed {
    logic               valid;
    side_t              side;
    logic [SqWidth-1:0] l2;
    logic [SqWidth-1:0] d;
  } front_t;

  typedef struct packed {
    logic                 valid;
    side_t                side;
    logic [RootWidth-1:0] ln;
    logic [RootWidth-1:0] hn;
  } root_t;

  typedef struct packed {
    logic                valid;
    status_e             status;
    logic                x_neg;
    logic                y_neg;
    logic [NumWidth-1:0] x_num;
    logic [NumWidth-1:0] y_num;
    logic [DenWidth-1:0] den;
  } frac_t;

  typedef struct packed {
    logic [RootWidth:0]   rem;
    logic [RootWidth-1:0] root;
  } sq_t;

  typedef struct packed {
    logic [DenWidth-1:0] rem;
    logic                qbit;
  } dv_t;

  // one digit of a square root: bring in two radicand bits, try 4*root+1
  function automatic sq_t sqrt_step(input logic [RootWidth:0] rem,
                                    input logic [RootWidth-1:0] root,
                                    input logic [1:0] pair);
    logic [RootWidth+2:0] rsh;
    logic [RootWidth+2:0] trial;
    sq_t r;
    rsh   = {rem, pair};
    trial = {1'b0, root, 2'b01};
    if (rsh >= trial) begin
      r.rem  = (RootWidth+1)'(rsh - trial);
      r.root = {root[RootWidth-2:0], 1'b1};
    end else begin
      r.rem  = rsh[RootWidth:0];
      r.root = {root[RootWidth-2:0], 1'b0};
    end
    return r;
  endfunction

  // one restoring division step, rem < den on entry
  function automatic dv_t div_step(input logic [DenWidth-1:0] rem,
                                   input logic nbit,
                                   input logic [DenWidth-1:0] den);
    logic [DenWidth:0] rsh;
    dv_t r;
    rsh = {rem, nbit};
    if (rsh >= {1'b0, den}) begin
      r.rem  = DenWidth'(rsh - {1'b0, den});
      r.qbit = 1'b1;
    end else begin
      r.rem  = rsh[DenWidth-1:0];
      r.qbit = 1'b0;
    end
    return r;
  endfunction

endpackage

@@ design/acr_front.sv @@
module acr_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            in_valid_i,
  input  acr_pkg::arc_in_t in_data_i,
  output acr_pkg::front_t  front_o
);
  import acr_pkg::*;

  // stage 1: chord and sums
  logic                  v1_q;
  logic [MagWidth-1:0]   vx1_q, vy1_q, sx1_q, sy1_q;
  logic [CoordWidth-2:0] r1_q;
  logic                  cc1_q;
  // stage 2: sign/magnitude
  logic                  v2_q;
  side_t                 side2_q;
  logic                  zero2_q;
  logic [CoordWidth-2:0] r2_q;
  // stage 3: squares
  logic                  v3_q;
  side_t                 side3_q;
  logic                  zero3_q;
  logic [SqWidth-1:0]    mx2_q, my2_q;
  logic [2*CoordWidth-3:0] rr3_q;
  // stage 4: L2 and 4r^2
  logic                  v4_q;
  side_t                 side4_q;
  logic                  zero4_q;
  logic [SqWidth-1:0]    l2_4_q;
  logic [2*CoordWidth-1:0] r4_4_q;
  // stage 5: checks
  logic                  v5_q;
  side_t                 side5_q;
  logic [SqWidth-1:0]    l2_5_q, d5_q;

  side_t side2_d;
  side_t side5_d;
  logic [SqWidth-1:0] r4_ext;

  always_comb begin
    side2_d.vx_neg  = vx1_q[MagWidth-1];
    side2_d.vy_neg  = vy1_q[MagWidth-1];
    side2_d.sx_neg  = sx1_q[MagWidth-1];
    side2_d.sy_neg  = sy1_q[MagWidth-1];
    side2_d.vx_mag  = vx1_q[MagWidth-1] ? -vx1_q : vx1_q;
    side2_d.vy_mag  = vy1_q[MagWidth-1] ? -vy1_q : vy1_q;
    side2_d.sx_mag  = sx1_q[MagWidth-1] ? -sx1_q : sx1_q;
    side2_d.sy_mag  = sy1_q[MagWidth-1] ? -sy1_q : sy1_q;
    side2_d.concave = cc1_q;
    side2_d.status  = StOk;
  end

  assign r4_ext = SqWidth'(r4_4_q);

  // zero chord wins over short radius
  always_comb begin
    side5_d = side4_q;
    if (zero4_q) begin
      side5_d.status = StZero;
    end else if (r4_ext < l2_4_q) begin
      side5_d.status = StShort;
    end else begin
      side5_d.status = StOk;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      vx1_q <= {in_data_i.end_x[CoordWidth-1], in_data_i.end_x}
             - {in_data_i.start_x[CoordWidth-1], in_data_i.start_x};
      vy1_q <= {in_data_i.end_y[CoordWidth-1], in_data_i.end_y}
             - {in_data_i.start_y[CoordWidth-1], in_data_i.start_y};
      sx1_q <= {in_data_i.end_x[CoordWidth-1], in_data_i.end_x}
             + {in_data_i.start_x[CoordWidth-1], in_data_i.start_x};
      sy1_q <= {in_data_i.end_y[CoordWidth-1], in_data_i.end_y}
             + {in_data_i.start_y[CoordWidth-1], in_data_i.start_y};
      r1_q  <= in_data_i.arc_radius;
      cc1_q <= in_data_i.concave;

      side2_q <= side2_d;
      zero2_q <= (vx1_q == '0) && (vy1_q == '0);
      r2_q    <= r1_q;

      side3_q <= side2_q;
      zero3_q <= zero2_q;
      mx2_q   <= SqWidth'(side2_q.vx_mag) * SqWidth'(side2_q.vx_mag);
      my2_q   <= SqWidth'(side2_q.vy_mag) * SqWidth'(side2_q.vy_mag);
      rr3_q   <= (2*CoordWidth-2)'(r2_q) * (2*CoordWidth-2)'(r2_q);

      side4_q <= side3_q;
      zero4_q <= zero3_q;
      l2_4_q  <= mx2_q + my2_q;
      r4_4_q  <= {rr3_q, 2'b00};

      side5_q <= side5_d;
      l2_5_q  <= l2_4_q;
      d5_q    <= r4_ext - l2_4_q;
    end
  end

  assign front_o.valid = v5_q;
  assign front_o.side  = side5_q;
  assign front_o.l2    = l2_5_q;
  assign front_o.d     = d5_q;

endmodule

@@ design/acr_sqrt.sv @@
module acr_sqrt (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  acr_pkg::front_t front_i,
  output acr_pkg::root_t  root_o
);
  import acr_pkg::*;

  // one result bit per stage for both roots
  logic                 v_q    [RootWidth];
  side_t                side_q [RootWidth];
  logic [SqWidth-1:0]   srcl_q [RootWidth];
  logic [SqWidth-1:0]   srch_q [RootWidth];
  logic [RootWidth:0]   reml_q [RootWidth];
  logic [RootWidth:0]   remh_q [RootWidth];
  logic [RootWidth-1:0] rtl_q  [RootWidth];
  logic [RootWidth-1:0] rth_q  [RootWidth];

  for (genvar k = 0; k < RootWidth; k++) begin : g_stage
    // radicand is src shifted up by 2*GuardBits; lower pairs are zero
    localparam int P = SqWidth - 2 - 2 * k;
    logic                 v_in;
    side_t                side_in;
    logic [SqWidth-1:0]   srcl_in, srch_in;
    logic [RootWidth:0]   reml_in, remh_in;
    logic [RootWidth-1:0] rtl_in, rth_in;
    logic [1:0]           pl, ph;
    sq_t                  nl, nh;

    if (k == 0) begin : g_first
      assign v_in    = front_i.valid;
      assign side_in = front_i.side;
      assign srcl_in = front_i.l2;
      assign srch_in = front_i.d;
      assign reml_in = '0;
      assign remh_in = '0;
      assign rtl_in  = '0;
      assign rth_in  = '0;
    end else begin : g_next
      assign v_in    = v_q[k-1];
      assign side_in = side_q[k-1];
      assign srcl_in = srcl_q[k-1];
      assign srch_in = srch_q[k-1];
      assign reml_in = reml_q[k-1];
      assign remh_in = remh_q[k-1];
      assign rtl_in  = rtl_q[k-1];
      assign rth_in  = rth_q[k-1];
    end

    if (P >= 0) begin : g_pair
      assign pl = srcl_in[P+1:P];
      assign ph = srch_in[P+1:P];
    end else begin : g_guard
      assign pl = 2'b00;
      assign ph = 2'b00;
    end

    assign nl = sqrt_step(reml_in, rtl_in, pl);
    assign nh = sqrt_step(remh_in, rth_in, ph);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en_i) begin
        v_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        side_q[k] <= side_in;
        srcl_q[k] <= srcl_in;
        srch_q[k] <= srch_in;
        reml_q[k] <= nl.rem;
        remh_q[k] <= nh.rem;
        rtl_q[k]  <= nl.root;
        rth_q[k]  <= nh.root;
      end
    end
  end

  assign root_o.valid = v_q[RootWidth-1];
  assign root_o.side  = side_q[RootWidth-1];
  assign root_o.ln    = rtl_q[RootWidth-1];
  assign root_o.hn    = rth_q[RootWidth-1];

endmodule

@@ design/acr_mix.sv @@
module acr_mix (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  acr_pkg::root_t root_i,
  output acr_pkg::frac_t frac_o
);
  import acr_pkg::*;

  // numerators (s*ln +- perp*hn) built from split partial products
  logic [5:0] v_q;
  status_e    st_q [6];
  logic [RootWidth-1:0] ln_q [5];

  // stage 1: partial products
  logic [MagWidth+SplitLo-1:0] xal_q, xbl_q, yal_q, ybl_q;
  logic [MagWidth+SplitHi-1:0] xah_q, xbh_q, yah_q, ybh_q;
  logic xan1_q, xbn1_q, yan1_q, ybn1_q;
  // stage 2: magnitudes
  logic [ProdWidth-1:0] xa2_q, xb2_q, ya2_q, yb2_q;
  logic xan2_q, xbn2_q, yan2_q, ybn2_q;
  // stage 3: two's complement
  logic [SumWidth-1:0] xa3_q, xb3_q, ya3_q, yb3_q;
  // stage 4: sums
  logic [SumWidth-1:0] xs4_q, ys4_q;
  // stage 5: magnitude of sum
  logic [NumWidth-1:0] xm5_q, ym5_q;
  logic                xn5_q, yn5_q;
  // stage 6: rounding bias
  logic [NumWidth-1:0] xn6_q, yn6_q;
  logic                xs6_q, ys6_q;
  logic [DenWidth-1:0] den6_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[4:0], root_i.valid};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      st_q[0] <= root_i.side.status;
      ln_q[0] <= root_i.ln;
      for (int i = 1; i < 6; i++) begin
        st_q[i] <= st_q[i-1];
      end
      for (int i = 1; i < 5; i++) begin
        ln_q[i] <= ln_q[i-1];
      end

      xal_q <= (MagWidth+SplitLo)'(root_i.side.sx_mag)
             * (MagWidth+SplitLo)'(root_i.ln[SplitLo-1:0]);
      xah_q <= (MagWidth+SplitHi)'(root_i.side.sx_mag)
             * (MagWidth+SplitHi)'(root_i.ln[RootWidth-1:SplitLo]);
      xbl_q <= (MagWidth+SplitLo)'(root_i.side.vy_mag)
             * (MagWidth+SplitLo)'(root_i.hn[SplitLo-1:0]);
      xbh_q <= (MagWidth+SplitHi)'(root_i.side.vy_mag)
             * (MagWidth+SplitHi)'(root_i.hn[RootWidth-1:SplitLo]);
      yal_q <= (MagWidth+SplitLo)'(root_i.side.sy_mag)
             * (MagWidth+SplitLo)'(root_i.ln[SplitLo-1:0]);
      yah_q <= (MagWidth+SplitHi)'(root_i.side.sy_mag)
             * (MagWidth+SplitHi)'(root_i.ln[RootWidth-1:SplitLo]);
      ybl_q <= (MagWidth+SplitLo)'(root_i.side.vx_mag)
             * (MagWidth+SplitLo)'(root_i.hn[SplitLo-1:0]);
      ybh_q <= (MagWidth+SplitHi)'(root_i.side.vx_mag)
             * (MagWidth+SplitHi)'(root_i.hn[RootWidth-1:SplitLo]);
      // x adds +Vy*hn when concave, y adds -Vx*hn when concave
      xan1_q <= root_i.side.sx_neg;
      xbn1_q <= root_i.side.concave ~^ root_i.side.vy_neg;
      yan1_q <= root_i.side.sy_neg;
      ybn1_q <= root_i.side.concave ^ root_i.side.vx_neg;

      xa2_q  <= ProdWidth'(xal_q) + (ProdWidth'(xah_q) << SplitLo);
      xb2_q  <= ProdWidth'(xbl_q) + (ProdWidth'(xbh_q) << SplitLo);
      ya2_q  <= ProdWidth'(yal_q) + (ProdWidth'(yah_q) << SplitLo);
      yb2_q  <= ProdWidth'(ybl_q) + (ProdWidth'(ybh_q) << SplitLo);
      xan2_q <= xan1_q;
      xbn2_q <= xbn1_q;
      yan2_q <= yan1_q;
      ybn2_q <= ybn1_q;

      xa3_q <= xan2_q ? -SumWidth'(xa2_q) : SumWidth'(xa2_q);
      xb3_q <= xbn2_q ? -SumWidth'(xb2_q) : SumWidth'(xb2_q);
      ya3_q <= yan2_q ? -SumWidth'(ya2_q) : SumWidth'(ya2_q);
      yb3_q <= ybn2_q ? -SumWidth'(yb2_q) : SumWidth'(yb2_q);

      xs4_q <= xa3_q + xb3_q;
      ys4_q <= ya3_q + yb3_q;

      xn5_q <= xs4_q[SumWidth-1];
      yn5_q <= ys4_q[SumWidth-1];
      xm5_q <= NumWidth'(xs4_q[SumWidth-1] ? -xs4_q : xs4_q);
      ym5_q <= NumWidth'(ys4_q[SumWidth-1] ? -ys4_q : ys4_q);

      xn6_q  <= xm5_q + NumWidth'(ln_q[4]);
      yn6_q  <= ym5_q + NumWidth'(ln_q[4]);
      xs6_q  <= xn5_q;
      ys6_q  <= yn5_q;
      den6_q <= {ln_q[4], 1'b0};
    end
  end

  assign frac_o.valid  = v_q[5];
  assign frac_o.status = st_q[5];
  assign frac_o.x_neg  = xs6_q;
  assign frac_o.y_neg  = ys6_q;
  assign frac_o.x_num  = xn6_q;
  assign frac_o.y_num  = yn6_q;
  assign frac_o.den    = den6_q;

endmodule

@@ design/acr_div.sv @@
module acr_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  acr_pkg::frac_t    frac_i,
  output logic              res_valid_o,
  output acr_pkg::arc_out_t res_data_o
);
  import acr_pkg::*;

  localparam int HiWidth = NumWidth - QuotWidth;

  typedef struct packed {
    logic [DenWidth-1:0]  rem;
    logic [QuotWidth-1:0] quo;
    logic [QuotWidth-1:0] low;
    logic                 sat;
    logic                 neg;
  } lane_t;

  // stage 0: overflow check; the quotient overflows iff num >> QuotWidth >= den
  logic                v0_q;
  status_e             st0_q;
  logic [DenWidth-1:0] den0_q;
  lane_t               lx0_q, ly0_q;

  logic                v_q   [QuotWidth];
  status_e             st_q  [QuotWidth];
  logic [DenWidth-1:0] den_q [QuotWidth];
  lane_t               lx_q  [QuotWidth];
  lane_t               ly_q  [QuotWidth];

  logic     vo_q;
  arc_out_t res_q;

  function automatic lane_t lane_init(input logic [NumWidth-1:0] num,
                                      input logic [DenWidth-1:0] den,
                                      input logic neg);
    lane_t l;
    l.sat = num[NumWidth-1:QuotWidth] >= HiWidth'(den);
    l.rem = num[QuotWidth +: DenWidth];
    l.low = num[QuotWidth-1:0];
    l.quo = '0;
    l.neg = neg;
    return l;
  endfunction

  function automatic lane_t lane_step(input lane_t l, input int unsigned j,
                                      input logic [DenWidth-1:0] den);
    dv_t   s;
    lane_t r;
    s     = div_step(l.rem, l.low[QuotWidth-1-j], den);
    r     = l;
    r.rem = s.rem;
    r.quo = {l.quo[QuotWidth-2:0], s.qbit};
    return r;
  endfunction

  function automatic logic [CoordWidth-1:0] lane_out(input lane_t l);
    logic [CoordWidth-1:0] q;
    q = {1'b0, l.quo};
    if (l.sat) begin
      return l.neg ? {1'b1, {QuotWidth{1'b0}}} : {1'b0, {QuotWidth{1'b1}}};
    end
    return l.neg ? -q : q;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      vo_q <= 1'b0;
    end else if (en_i) begin
      v0_q <= frac_i.valid;
      vo_q <= v_q[QuotWidth-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      st0_q  <= frac_i.status;
      den0_q <= frac_i.den;
      lx0_q  <= lane_init(frac_i.x_num, frac_i.den, frac_i.x_neg);
      ly0_q  <= lane_init(frac_i.y_num, frac_i.den, frac_i.y_neg);
    end
  end

  for (genvar j = 0; j < QuotWidth; j++) begin : g_stage
    logic                v_in;
    status_e             st_in;
    logic [DenWidth-1:0] den_in;
    lane_t               lx_in, ly_in;

    if (j == 0) begin : g_first
      assign v_in   = v0_q;
      assign st_in  = st0_q;
      assign den_in = den0_q;
      assign lx_in  = lx0_q;
      assign ly_in  = ly0_q;
    end else begin : g_next
      assign v_in   = v_q[j-1];
      assign st_in  = st_q[j-1];
      assign den_in = den_q[j-1];
      assign lx_in  = lx_q[j-1];
      assign ly_in  = ly_q[j-1];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[j] <= 1'b0;
      end else if (en_i) begin
        v_q[j] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        st_q[j]  <= st_in;
        den_q[j] <= den_in;
        lx_q[j]  <= lane_step(lx_in, j, den_in);
        ly_q[j]  <= lane_step(ly_in, j, den_in);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_q.status <= st_q[QuotWidth-1];
      if (st_q[QuotWidth-1] != StOk) begin
        res_q.centre_x <= '0;
        res_q.centre_y <= '0;
      end else begin
        res_q.centre_x <= lane_out(lx_q[QuotWidth-1]);
        res_q.centre_y <= lane_out(ly_q[QuotWidth-1]);
      end
    end
  end

  assign res_valid_o = vo_q;
  assign res_data_o  = res_q;

endmodule

@@ design/arc_centre_from_radius.sv @@
// Channel  Direction  Handshake                 Payload
// in       input      in_valid_i / in_ready_o   in_data_i  (arc_in_t)
// out      output     out_valid_o / out_ready_i out_data_o (arc_out_t)
//
// One transaction per cycle while the buffer has room; in-order results.
// From acceptance, data passes 5 front stages, one square-root stage
// per root bit (63), 6 product stages, and CoordWidth+1 divider stages
// (overflow check, one quotient bit per stage, output register).
// The whole pipeline advances together while the 2-entry output buffer has
// room; in_ready_o is registered state, so no path runs from out_ready_i.
// Reset clears all valid bits and the buffer; no clearing pass is needed.
module arc_centre_from_radius (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  acr_pkg::arc_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output acr_pkg::arc_out_t out_data_o
);
  import acr_pkg::*;

  localparam int FifoDepth = 2;
  localparam int CntWidth  = $clog2(FifoDepth + 1);

  logic     en;
  front_t   front;
  root_t    root;
  frac_t    frac;
  logic     res_valid;
  arc_out_t res_data;

  arc_out_t            buf_q [FifoDepth];
  logic                wr_ptr_q, rd_ptr_q;
  logic [CntWidth-1:0] cnt_q;
  logic                push, pop;

  assign en         = cnt_q != CntWidth'(FifoDepth);
  assign in_ready_o = en;

  acr_front u_front (
    .clk_i, .rst_ni, .en_i(en),
    .in_valid_i, .in_data_i,
    .front_o(front)
  );

  acr_sqrt u_sqrt (
    .clk_i, .rst_ni, .en_i(en),
    .front_i(front),
    .root_o(root)
  );

  acr_mix u_mix (
    .clk_i, .rst_ni, .en_i(en),
    .root_i(root),
    .frac_o(frac)
  );

  acr_div u_div (
    .clk_i, .rst_ni, .en_i(en),
    .frac_i(frac),
    .res_valid_o(res_valid),
    .res_data_o(res_data)
  );

  assign push = en && res_valid;
  assign pop  = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= '0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop)  rd_ptr_q <= ~rd_ptr_q;
      cnt_q <= cnt_q + CntWidth'(push) - CntWidth'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      buf_q[wr_ptr_q] <= res_data;
    end
  end

  assign out_valid_o = cnt_q != '0;
  assign out_data_o  = buf_q[rd_ptr_q];

`ifndef SYNTH
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntWidth'(FifoDepth))
    else $error("output buffer overfilled");

  a_frozen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(res_valid))
    else $error("pipeline moved while stalled");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status != StOk |->
      out_data_o.centre_x == '0 && out_data_o.centre_y == '0)
    else $error("error result with nonzero centre");
`endif

endmodule
